// ----- hw/rtl/mcut_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helper functions of the bi-objective max-cut evaluator
package mcut_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 16;

  localparam int VIDX_W      = 6;
  localparam int VCNT_W      = 7;
  localparam int IN_WEIGHT_W = 16;
  localparam int SUM_W       = 27;
  localparam int ADDR_W      = 2 * VIDX_W;
  localparam int TABLE_DEPTH = 1 << ADDR_W;
  localparam int WORD_W      = 2 * WEIGHT_BITS;
  localparam int PART_W      = 1 << VIDX_W;

  localparam longint WeightHi = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
  localparam longint WeightLo = -WeightHi - 1;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  // one vertex pair issued by the sequencer
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              cut;
    logic              last;
  } pair_t;

  // saturate an incoming weight to the stored width
  function automatic weight_t fit_weight(logic signed [IN_WEIGHT_W-1:0] w);
    logic signed [63:0] wx;
    logic signed [63:0] r;
    wx = 64'(w);
    if (wx > WeightHi) begin
      r = WeightHi;
    end else if (wx < WeightLo) begin
      r = WeightLo;
    end else begin
      r = wx;
    end
    return r[WEIGHT_BITS-1:0];
  endfunction

  // sign extend a stored weight to the sum width
  function automatic sum_t ext_weight(weight_t w);
    logic signed [63:0] wx;
    wx = 64'(w);
    return wx[SUM_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/biobjective_maxcut_evaluator.sv -----
`timescale 1ns / 1ps
// top level of the bi-objective weighted max-cut evaluator
//
// Holds two signed edge-weight tables over up to 64 vertices in one memory
// of 4096 words (address first_vertex*64+second_vertex, both weights in a
// word). A write transaction (cmd 0) stores one edge and gives no result;
// writes with first_vertex not below second_vertex are dropped. An
// evaluate transaction (cmd 1) walks every pair i<j below the vertex
// count, one memory read per cycle through a single accumulator, and
// returns both cut sums as one result; with fewer than two vertices in use
// no pair is read. Only one evaluation is in flight; the input stalls
// until its result is in the output register, which then waits for the
// consumer while new transactions are accepted. After reset the block
// runs a clearing pass over all 4096 words that zeroes the memory, with
// the input stalled; vertex_count writes are taken at any time.
module biobjective_maxcut_evaluator import mcut_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [VCNT_W-1:0]             cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [VIDX_W-1:0]             first_vertex_i,
  input  logic [VIDX_W-1:0]             second_vertex_i,
  input  logic signed [IN_WEIGHT_W-1:0] weight_a_i,
  input  logic signed [IN_WEIGHT_W-1:0] weight_b_i,
  input  logic [PART_W-1:0]             partition_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SUM_W-1:0]       cut_weight_a_o,
  output logic signed [SUM_W-1:0]       cut_weight_b_o
);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [VCNT_W-1:0] vcount_q;
  logic [VCNT_W-1:0] n_eff;

  logic              in_acc;
  logic              eval_acc;
  logic              wr_acc;
  logic              wr_ok;
  logic              out_free;

  // memory port controls
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  pair_t             pair;
  logic              seq_start;
  logic              add_q;
  logic              acc_clr;
  sum_t              sum_a, sum_b;

  logic              out_valid_q, out_valid_d;
  sum_t              out_a_q, out_b_q;
  logic              out_load;

  // vertex count clamped to what the tables hold
  assign n_eff = (vcount_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcount_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign eval_acc = in_acc && (cmd_e'(cmd_i) == CMD_EVAL);
  assign wr_acc   = in_acc && (cmd_e'(cmd_i) == CMD_WRITE);
  // misordered edges and vertices beyond the table are dropped
  assign wr_ok    = (first_vertex_i < second_vertex_i) &&
                    ({1'b0, second_vertex_i} < VCNT_W'(MAX_VERTICES));
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (eval_acc) begin
          // fewer than two vertices means no pairs at all
          state_d = (n_eff < VCNT_W'(2)) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (pair.valid && pair.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer state
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    seq_start  = eval_acc && (n_eff >= VCNT_W'(2));
    acc_clr    = eval_acc;
    out_load   = (state_q == ST_FIN) && out_free;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_acc && wr_ok;
      mem_waddr = {first_vertex_i, second_vertex_i};
      mem_wdata = {fit_weight(weight_a_i), fit_weight(weight_b_i)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      vcount_q  <= VCNT_W'(MAX_VERTICES);
      add_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      add_q     <= pair.valid && pair.cut;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  mcut_wmem u_wmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (pair.valid),
    .raddr_i (pair.addr),
    .rdata_o (mem_rdata)
  );

  mcut_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (seq_start),
    .n_i         (n_eff),
    .partition_i (partition_i),
    .pair_o      (pair)
  );

  // read data lands in the cycle after the pair is issued
  mcut_acc u_acc (
    .clk_i   (clk_i),
    .clr_i   (acc_clr),
    .add_i   (add_q),
    .wa_i    (mem_rdata[WORD_W-1:WEIGHT_BITS]),
    .wb_i    (mem_rdata[WEIGHT_BITS-1:0]),
    .sum_a_o (sum_a),
    .sum_b_o (sum_b)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_a_q <= sum_a;
      out_b_q <= sum_b;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cut_weight_a_o = out_a_q;
  assign cut_weight_b_o = out_b_q;

endmodule

// ----- hw/rtl/mcut_wmem.sv -----
`timescale 1ns / 1ps
// edge weight memory, one word holds both objective weights of one edge
module mcut_wmem import mcut_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mcut_seq.sv -----
`timescale 1ns / 1ps
// pair sequencer, walks all vertex pairs i<j one per cycle
module mcut_seq import mcut_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VCNT_W-1:0] n_i,
  input  logic [PART_W-1:0] partition_i,
  output pair_t             pair_o
);

  logic              busy_q, busy_d;
  logic [VIDX_W-1:0] i_q, i_d;
  logic [VIDX_W-1:0] j_q, j_d;
  logic [VCNT_W-1:0] n_q, n_d;
  logic [PART_W-1:0] part_q, part_d;
  logic              j_end;
  logic              i_end;

  assign j_end = ({1'b0, j_q} == (n_q - VCNT_W'(1)));
  assign i_end = ({1'b0, i_q} == (n_q - VCNT_W'(2)));

  always_comb begin
    pair_o.valid = busy_q;
    pair_o.addr  = {i_q, j_q};
    pair_o.cut   = part_q[i_q] ^ part_q[j_q];
    pair_o.last  = j_end && i_end;
  end

  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    n_d    = n_q;
    part_d = part_q;
    if (start_i) begin
      busy_d = 1'b1;
      i_d    = '0;
      j_d    = VIDX_W'(1);
      n_d    = n_i;
      part_d = partition_i;
    end else if (busy_q) begin
      if (j_end) begin
        if (i_end) begin
          busy_d = 1'b0;
        end else begin
          i_d = i_q + VIDX_W'(1);
          j_d = i_q + VIDX_W'(2);
        end
      end else begin
        j_d = j_q + VIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    n_q    <= n_d;
    part_q <= part_d;
  end

endmodule

// ----- hw/rtl/mcut_acc.sv -----
`timescale 1ns / 1ps
// shared accumulator for both cut sums
module mcut_acc import mcut_pkg::*; (
  input  logic    clk_i,
  input  logic    clr_i,
  input  logic    add_i,
  input  weight_t wa_i,
  input  weight_t wb_i,
  output sum_t    sum_a_o,
  output sum_t    sum_b_o
);

  sum_t sum_a_q, sum_a_d;
  sum_t sum_b_q, sum_b_d;

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (clr_i) begin
      sum_a_d = '0;
      sum_b_d = '0;
    end else if (add_i) begin
      sum_a_d = sum_a_q + ext_weight(wa_i);
      sum_b_d = sum_b_q + ext_weight(wb_i);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_a_q <= sum_a_d;
    sum_b_q <= sum_b_d;
  end

  assign sum_a_o = sum_a_q;
  assign sum_b_o = sum_b_q;

endmodule

// ----- hw/rtl/mcut_chk.sv -----
`timescale 1ns / 1ps
// port-level checker for the max-cut evaluator and its bind
module mcut_chk import mcut_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    cmd_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [SUM_W-1:0] cut_weight_a_o
);

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cut_weight_a_o))
    else $error("stalled result dropped or changed");

  // input stays stalled in the first cycle after reset
  a_reset_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during memory clear");

  // an accepted evaluation stalls the input in the following cycle
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_e'(cmd_i) == CMD_EVAL) |=> in_stall_o)
    else $error("input accepted while evaluating");

  // a write transaction never makes a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_e'(cmd_i) == CMD_WRITE) && !out_valid_o
    |=> !out_valid_o)
    else $error("result after write transaction");

endmodule

bind biobjective_maxcut_evaluator mcut_chk u_mcut_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .cmd_i          (cmd_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cut_weight_a_o (cut_weight_a_o)
);

// ----- sim/biobjective_maxcut_evaluator_test.sv -----
`timescale 1ns / 1ps
// testbench of the bi-objective max-cut evaluator: directed table, random phases, result checking
module biobjective_maxcut_evaluator_test;
  import mcut_pkg::*;

  // table addressing: first vertex in the upper index bits
  localparam int STRIDE        = 1 << VIDX_W;
  localparam int CYCLE_LIMIT   = 3_000_000;
  // margin after the last write before touching vertex_count
  localparam int SETTLE_CYCLES = 16;
  // wait for stray results, longer than the longest evaluation
  localparam int EVAL_CYCLES   = 2100;
  localparam int PHASE_ITEMS   = 27;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    sum_t a;
    sum_t b;
  } cut_pair_t;

  // one input transaction plus an optional hand-typed expectation
  typedef struct packed {
    cmd_e                          cmd;
    logic [VIDX_W-1:0]             v1;
    logic [VIDX_W-1:0]             v2;
    logic signed [IN_WEIGHT_W-1:0] wa;
    logic signed [IN_WEIGHT_W-1:0] wb;
    logic [PART_W-1:0]             part;
    logic                          typed;
    sum_t                          exp_a;
    sum_t                          exp_b;
  } txn_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [VCNT_W-1:0]             cfg_wdata_i     = 7'd64;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic                          cmd_i           = CMD_WRITE;
  logic [VIDX_W-1:0]             first_vertex_i  = '0;
  logic [VIDX_W-1:0]             second_vertex_i = '0;
  logic signed [IN_WEIGHT_W-1:0] weight_a_i      = '0;
  logic signed [IN_WEIGHT_W-1:0] weight_b_i      = '0;
  logic [PART_W-1:0]             partition_i     = '0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  sum_t                          cut_weight_a_o;
  sum_t                          cut_weight_b_o;

  // shadow copy of the two weight tables and of vertex_count
  weight_t           stored_a [TABLE_DEPTH];
  weight_t           stored_b [TABLE_DEPTH];
  logic [VCNT_W-1:0] vertex_setting;

  // cut sums owed by the block, oldest first
  cut_pair_t cut_sums_due [$];

  int  fail_count   = 0;
  int  cycle_count  = 0;
  int  sent_count   = 0;
  int  result_count = 0;
  int  out_hold     = 0;
  bit  in_burst     = 1'b0;
  bit  out_burst    = 1'b0;

  // directed part: extremes, both commands, misordered writes, overwrite,
  // unused fields carrying junk; typed rows are easy to read off by hand
  txn_t directed_rows [0:18] = '{
    // fresh tables: any partition cuts nothing
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'h0, 1'b1, 27'sd0, 27'sd0},
    // vertex and weight fields are junk on an evaluate
    '{CMD_EVAL,  6'd63, 6'd0,  16'sh7fff, 16'sh8000, '1,    1'b1, 27'sd0, 27'sd0},
    // weight extremes; partition field is junk on a write
    '{CMD_WRITE, 6'd0,  6'd1,  16'sh7fff, 16'sh8000, '1,    1'b0, 27'sd0, 27'sd0},
    '{CMD_WRITE, 6'd0,  6'd63, 16'sh8000, 16'sh7fff, 64'h0, 1'b0, 27'sd0, 27'sd0},
    '{CMD_WRITE, 6'd62, 6'd63, 16'sh0001, 16'shffff, 64'h0, 1'b0, 27'sd0, 27'sd0},
    // equal vertices and reversed vertices are dropped
    '{CMD_WRITE, 6'd5,  6'd5,  16'sh1234, 16'sh1234, 64'h0, 1'b0, 27'sd0, 27'sd0},
    '{CMD_WRITE, 6'd63, 6'd0,  16'sh7fff, 16'sh7fff, 64'h0, 1'b0, 27'sd0, 27'sd0},
    // vertex 0 alone: edges 0-1 and 0-63
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'h1, 1'b1, -27'sd1, -27'sd1},
    // vertex 63 alone: edges 0-63 and 62-63
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'h8000_0000_0000_0000,
      1'b1, -27'sd32767, 27'sd32766},
    // vertex 62 alone: only edge 62-63 is stored
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'h4000_0000_0000_0000,
      1'b1, 27'sd1, -27'sd1},
    // later write replaces the earlier one
    '{CMD_WRITE, 6'd0,  6'd1,  16'shfffb, 16'sh0007, 64'h0, 1'b0, 27'sd0, 27'sd0},
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'h1, 1'b0, 27'sd0, 27'sd0},
    '{CMD_WRITE, 6'd1,  6'd2,  16'sh8000, 16'sh8000, 64'h0, 1'b0, 27'sd0, 27'sd0},
    '{CMD_WRITE, 6'd2,  6'd3,  16'sh7fff, 16'sh7fff, 64'h0, 1'b0, 27'sd0, 27'sd0},
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'h5555_5555_5555_5555,
      1'b0, 27'sd0, 27'sd0},
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'haaaa_aaaa_aaaa_aaaa,
      1'b0, 27'sd0, 27'sd0},
    // everyone on one side
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, '1,    1'b1, 27'sd0, 27'sd0},
    // zero weight erases an edge
    '{CMD_WRITE, 6'd0,  6'd63, 16'sh0000, 16'sh0000, 64'h0, 1'b0, 27'sd0, 27'sd0},
    '{CMD_EVAL,  6'd0,  6'd0,  16'sh0000, 16'sh0000, 64'h0000_0000_ffff_ffff,
      1'b0, 27'sd0, 27'sd0}
  };

  // vertex_count per random phase: reset value, below two, above the
  // vertex limit, all ones and all zeros among them
  logic [VCNT_W-1:0] phase_counts [10] = '{
    7'd64, 7'd0, 7'd127, 7'd2, 7'd1, 7'd9, 7'd65, 7'd17, 7'd3, 7'd64
  };

  biobjective_maxcut_evaluator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .weight_a_i      (weight_a_i),
    .weight_b_i      (weight_b_i),
    .partition_i     (partition_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cut_weight_a_o  (cut_weight_a_o),
    .cut_weight_b_o  (cut_weight_b_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // stored weight saturates to the table width
  function automatic weight_t clamp_weight(logic signed [IN_WEIGHT_W-1:0] w);
    longint x;
    x = w;
    if (x > WeightHi) begin
      x = WeightHi;
    end else if (x < WeightLo) begin
      x = WeightLo;
    end
    return weight_t'(x);
  endfunction

  // both cut sums over pairs i<j below the effective vertex count
  function automatic cut_pair_t cut_sums(logic [PART_W-1:0] part);
    cut_pair_t r;
    longint    acc_a;
    longint    acc_b;
    int        n;
    n = (int'(vertex_setting) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_setting);
    acc_a = 0;
    acc_b = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (part[i] != part[j]) begin
          acc_a += stored_a[i * STRIDE + j];
          acc_b += stored_b[i * STRIDE + j];
        end
      end
    end
    r.a = acc_a[SUM_W-1:0];
    r.b = acc_b[SUM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [IN_WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return IN_WEIGHT_W'($urandom_range(0, 15)) - 16'sd8;
      default: return IN_WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [PART_W-1:0] rand_partition();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic note_mismatch(string what, sum_t want, sum_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // compare one accepted result against the oldest owed cut sums
  task automatic check_result(sum_t got_a, sum_t got_b);
    cut_pair_t want;
    if (cut_sums_due.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("unexpected result: a=%0d b=%0d", got_a, got_b);
      end
      return;
    end
    want = cut_sums_due.pop_front();
    if (got_a !== want.a) note_mismatch("cut_weight_a", want.a, got_a);
    if (got_b !== want.b) note_mismatch("cut_weight_b", want.b, got_b);
  endtask

  // drive one transaction, hold it until taken, then update the shadow state;
  // valid stays high between back-to-back transactions
  task automatic push_item(input txn_t s);
    int        gap;
    cut_pair_t owed;
    // every 16 transactions, sometimes switch to a stretch with no gaps
    if (sent_count % 16 == 0) in_burst = ($urandom_range(0, 3) == 0);
    sent_count++;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= s.cmd;
    first_vertex_i  <= s.v1;
    second_vertex_i <= s.v2;
    weight_a_i      <= s.wa;
    weight_b_i      <= s.wb;
    partition_i     <= s.part;
    do @(posedge clk_i); while (in_stall_o);
    if (s.cmd == CMD_WRITE) begin
      // misordered pairs leave the tables alone
      if (s.v1 < s.v2 && int'(s.v2) < MAX_VERTICES) begin
        stored_a[{s.v1, s.v2}] = clamp_weight(s.wa);
        stored_b[{s.v1, s.v2}] = clamp_weight(s.wb);
      end
    end else begin
      if (s.typed) begin
        owed.a = s.exp_a;
        owed.b = s.exp_b;
      end else begin
        owed = cut_sums(s.part);
      end
      cut_sums_due = {cut_sums_due, owed};
    end
  endtask

  // block is idle once every owed result is back and the last write settled
  task automatic wait_drained();
    while (cut_sums_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: take a transaction, then stall for a random count of cycles
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result(cut_weight_a_o, cut_weight_b_o);
      result_count++;
      if (result_count % 16 == 0) out_burst = ($urandom_range(0, 3) == 0);
      out_hold = out_burst ? 0 : $urandom_range(0, 5);
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall_i <= (out_hold > 0);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    txn_t t;
    int   n_eff;
    int   kind;
    foreach (stored_a[k]) begin
      stored_a[k] = '0;
      stored_b[k] = '0;
    end
    vertex_setting = 7'd64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows at the reset vertex count; the clearing pass after
    // reset shows up as a long stall on the first transaction
    foreach (directed_rows[r]) push_item(directed_rows[r]);
    in_valid_i <= 1'b0;

    foreach (phase_counts[p]) begin
      // vertex_count only changes while the block is idle
      wait_drained();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= phase_counts[p];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      vertex_setting = phase_counts[p];
      n_eff = (int'(vertex_setting) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_setting);

      repeat (PHASE_ITEMS) begin
        t = '0;
        t.wa = rand_weight();
        t.wb = rand_weight();
        t.part = rand_partition();
        t.v1 = VIDX_W'($urandom);
        t.v2 = VIDX_W'($urandom);
        if ($urandom_range(0, 99) < 35) begin
          // evaluate with junk in the unused fields
          t.cmd = CMD_EVAL;
        end else begin
          t.cmd = CMD_WRITE;
          kind = $urandom_range(0, 9);
          if (kind < 7) begin
            // well-formed edge, mostly inside the vertices in use,
            // sometimes beyond them to leave stale edges behind
            if (n_eff >= 2 && $urandom_range(0, 4) != 0) begin
              t.v2 = VIDX_W'($urandom_range(1, n_eff - 1));
            end else begin
              t.v2 = VIDX_W'($urandom_range(1, STRIDE - 1));
            end
            t.v1 = VIDX_W'($urandom_range(0, int'(t.v2) - 1));
          end else if (kind < 9) begin
            // misordered or equal vertices
            t.v1 = VIDX_W'($urandom_range(0, STRIDE - 1));
            t.v2 = VIDX_W'($urandom_range(0, int'(t.v1)));
          end
        end
        push_item(t);
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    // catch stray results after the last one owed
    repeat (EVAL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mcut_pkg.sv
hw/rtl/mcut_wmem.sv
hw/rtl/mcut_seq.sv
hw/rtl/mcut_acc.sv
hw/rtl/biobjective_maxcut_evaluator.sv
hw/rtl/mcut_chk.sv
sim/biobjective_maxcut_evaluator_test.sv
